[rtl/rld_pkg.sv]
// Shared result types and kind codes for the log record deframer.
package rld_pkg;

  // Result kinds carried on the master-side tuser
  typedef enum logic [2:0] {
    KIND_HEADER    = 3'd0,
    KIND_KEY       = 3'd1,
    KIND_VALUE     = 3'd2,
    KIND_COMMIT    = 3'd3,
    KIND_BADSUM    = 3'd4,
    KIND_MALFORMED = 3'd5,
    KIND_TRUNC     = 3'd6
  } rld_kind_e;

  // Smallest payload that holds the type byte and both lengths
  localparam logic [31:0] MIN_PAYLOAD = 32'd9;

  // Number of result slots in the output queue
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);

  typedef struct packed {
    rld_kind_e   kind;
    logic [7:0]  byte_value;
    logic [7:0]  record_kind;
    logic [31:0] key_length;
    logic [31:0] value_length;
    logic        last_of_run;
  } rld_result_t;

  // Up to two results produced by one input item
  typedef struct packed {
    logic [1:0]  count;
    rld_result_t r0;
    rld_result_t r1;
  } rld_push_t;

endpackage

[rtl/rld_core.sv]
// Record parser: header gather, running hash, length tracking and verdict.
module rld_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_log_i,
  output rld_pkg::rld_push_t push_o
);
  import rld_pkg::*;

  localparam logic [2:0] PH_CKS  = 3'd0;
  localparam logic [2:0] PH_SIZE = 3'd1;
  localparam logic [2:0] PH_TYPE = 3'd2;
  localparam logic [2:0] PH_KLEN = 3'd3;
  localparam logic [2:0] PH_VLEN = 3'd4;
  localparam logic [2:0] PH_KEY  = 3'd5;
  localparam logic [2:0] PH_VAL  = 3'd6;
  localparam logic [2:0] PH_PAD  = 3'd7;

  logic [2:0]  phase_q, phase_d;
  logic [1:0]  hidx_q, hidx_d;
  logic [31:0] cks_q, cks_d;
  logic [31:0] psize_q, psize_d;
  logic [31:0] hash_q, hash_d;
  logic [31:0] pcount_q, pcount_d;
  logic [31:0] krem_q, krem_d;
  logic [31:0] vrem_q, vrem_d;
  logic [7:0]  htype_q, htype_d;
  logic        halted_q, halted_d;

  logic [31:0] gword;
  logic [31:0] gsrc;
  logic        gdone;
  logic [32:0] need;
  logic        has_a, has_v;
  rld_result_t res_a, res_v;
  logic        stop;

  // Place one little-endian byte into a word, clearing it on the first byte
  function automatic logic [31:0] gather(input logic [31:0] w, input logic [1:0] idx,
                                         input logic [7:0] b);
    logic [31:0] r;
    r = (idx == 2'd0) ? 32'd0 : w;
    r[{idx, 3'b000} +: 8] = b;
    return r;
  endfunction

  // Choose the next body phase from the remaining lengths
  function automatic logic [2:0] body_phase(input logic [31:0] k, input logic [31:0] v);
    logic [2:0] p;
    if (k != 32'd0) p = PH_KEY;
    else if (v != 32'd0) p = PH_VAL;
    else p = PH_PAD;
    return p;
  endfunction

  // Word being gathered in the current phase
  always_comb begin
    case (phase_q)
      PH_CKS:  gsrc = cks_q;
      PH_SIZE: gsrc = psize_q;
      PH_KLEN: gsrc = krem_q;
      PH_VLEN: gsrc = vrem_q;
      default: gsrc = 32'd0;
    endcase
  end

  assign gword = gather(gsrc, hidx_q, data_byte_i);
  assign gdone = (hidx_q == 2'd3);
  assign need  = {1'b0, krem_q} + {1'b0, gword};

  // Step the parser for one request
  always_comb begin
    phase_d  = phase_q;
    hidx_d   = hidx_q;
    cks_d    = cks_q;
    psize_d  = psize_q;
    hash_d   = hash_q;
    pcount_d = pcount_q;
    krem_d   = krem_q;
    vrem_d   = vrem_q;
    htype_d  = htype_q;
    halted_d = halted_q;
    has_a    = 1'b0;
    has_v    = 1'b0;
    stop     = 1'b0;
    res_a    = '0;
    res_v    = '0;

    if (step_i && !halted_q) begin
      if (end_of_log_i) begin
        if (!(phase_q == PH_CKS && hidx_q == 2'd0)) begin
          has_a      = 1'b1;
          res_a.kind = KIND_TRUNC;
          halted_d   = 1'b1;
        end
      end else if (phase_q == PH_CKS) begin
        cks_d  = gword;
        hidx_d = hidx_q + 2'd1;
        if (gdone) phase_d = PH_SIZE;
      end else if (phase_q == PH_SIZE) begin
        psize_d = gword;
        hidx_d  = hidx_q + 2'd1;
        if (gdone) begin
          if (gword < MIN_PAYLOAD) begin
            has_a      = 1'b1;
            res_a.kind = KIND_MALFORMED;
            halted_d   = 1'b1;
          end else begin
            phase_d  = PH_TYPE;
            hash_d   = 32'd0;
            pcount_d = 32'd0;
          end
        end
      end else begin
        // Hash and count every payload byte: h*31 + b
        hash_d   = (hash_q << 5) - hash_q + {24'd0, data_byte_i};
        pcount_d = pcount_q + 32'd1;
        case (phase_q)
          PH_TYPE: begin
            htype_d = data_byte_i;
            hidx_d  = 2'd0;
            phase_d = PH_KLEN;
          end
          PH_KLEN: begin
            krem_d = gword;
            hidx_d = hidx_q + 2'd1;
            if (gdone) phase_d = PH_VLEN;
          end
          PH_VLEN: begin
            vrem_d = gword;
            hidx_d = hidx_q + 2'd1;
            if (gdone) begin
              has_a = 1'b1;
              if (need > {1'b0, psize_q - MIN_PAYLOAD}) begin
                res_a.kind = KIND_MALFORMED;
                halted_d   = 1'b1;
                stop       = 1'b1;
              end else begin
                res_a.kind         = KIND_HEADER;
                res_a.record_kind  = htype_q;
                res_a.key_length   = krem_q;
                res_a.value_length = gword;
                phase_d            = body_phase(krem_q, gword);
              end
            end
          end
          PH_KEY: begin
            has_a            = 1'b1;
            res_a.kind       = KIND_KEY;
            res_a.byte_value = data_byte_i;
            krem_d           = krem_q - 32'd1;
            phase_d          = body_phase(krem_q - 32'd1, vrem_q);
          end
          PH_VAL: begin
            has_a            = 1'b1;
            res_a.kind       = KIND_VALUE;
            res_a.byte_value = data_byte_i;
            vrem_d           = vrem_q - 32'd1;
            phase_d          = body_phase(krem_q, vrem_q - 32'd1);
          end
          default: begin
          end
        endcase

        // Give the verdict at payload end
        if (!stop && phase_d >= PH_KEY && pcount_d == psize_q) begin
          has_v = 1'b1;
          if (hash_d == cks_q) begin
            res_v.kind = KIND_COMMIT;
          end else begin
            res_v.kind = KIND_BADSUM;
            halted_d   = 1'b1;
          end
          phase_d = PH_CKS;
          hidx_d  = 2'd0;
        end
      end
    end
  end

  // Order results: body result first, verdict after; mark the final one
  always_comb begin
    push_o       = '0;
    push_o.count = {1'b0, has_a} + {1'b0, has_v};
    if (has_a) begin
      push_o.r0             = res_a;
      push_o.r0.last_of_run = !has_v;
      push_o.r1             = res_v;
      push_o.r1.last_of_run = 1'b1;
    end else begin
      push_o.r0             = res_v;
      push_o.r0.last_of_run = 1'b1;
    end
  end

  // Hold parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_CKS;
      hidx_q   <= 2'd0;
      cks_q    <= 32'd0;
      psize_q  <= 32'd0;
      hash_q   <= 32'd0;
      pcount_q <= 32'd0;
      krem_q   <= 32'd0;
      vrem_q   <= 32'd0;
      htype_q  <= 8'd0;
      halted_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      hidx_q   <= hidx_d;
      cks_q    <= cks_d;
      psize_q  <= psize_d;
      hash_q   <= hash_d;
      pcount_q <= pcount_d;
      krem_q   <= krem_d;
      vrem_q   <= vrem_d;
      htype_q  <= htype_d;
      halted_q <= halted_d;
    end
  end

  // A halted parser produces nothing and keeps its phase
  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> (push_o.count == 2'd0) ##1 $stable(phase_q))
    else $error("halted parser produced results or moved");

  // Two results always end in a verdict
  a_pair_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.count == 2'd2) |->
      (push_o.r1.kind == KIND_COMMIT || push_o.r1.kind == KIND_BADSUM))
    else $error("second result is not a verdict");

endmodule

[rtl/rld_out_fifo.sv]
// Four-entry result queue between the parser and the master-side stream.
module rld_out_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rld_pkg::rld_push_t    push_i,
  input  logic                  pop_i,
  output rld_pkg::rld_result_t  head_o,
  output logic                  valid_o,
  output logic                  room_o
);
  import rld_pkg::*;

  rld_result_t           mem_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]  wr_q, wr_d;
  logic [OUT_PTR_W-1:0]  rd_q, rd_d;
  logic [OUT_PTR_W:0]    count_q, count_d;
  logic                  pop;

  assign pop     = pop_i && valid_o;
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_q];
  // Room for a full pair of results
  assign room_o  = (count_q <= (OUT_PTR_W+1)'(OUT_DEPTH - 2));

  assign wr_d    = wr_q + OUT_PTR_W'(push_i.count);
  assign rd_d    = rd_q + OUT_PTR_W'(pop);
  assign count_d = count_q + (OUT_PTR_W+1)'(push_i.count) - (OUT_PTR_W+1)'(pop);

  // Write incoming results
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_q] <= push_i.r0;
    if (push_i.count == 2'd2) mem_q[wr_q + OUT_PTR_W'(1)] <= push_i.r1;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  // Never push more than the free slots
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, count_q} + {{OUT_PTR_W{1'b0}}, push_i.count} - {{OUT_PTR_W+1{1'b0}}, pop})
      <= (OUT_PTR_W+2)'(OUT_DEPTH))
    else $error("result queue overflow");

  // Occupancy follows the pushes and pops of the previous cycle
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count == 2'd0 && !pop) |=> $stable(count_q))
    else $error("queue occupancy changed without a push or pop");

endmodule

[rtl/log_record_deframer.sv]
// Top level of the log record deframer: input register, parser and result queue.
//
//   group   dir  tdata                                   tuser            tlast
//   s_axis  in   [7:0] data_byte                         [0] end_of_log   -
//   m_axis  out  [7:0] byte_value [15:8] record_kind     [2:0] kind       last_of_run
//                [47:16] key_length [79:48] value_length
//
// One input request and one parsed item per cycle while the queue has room; the
// four-entry result queue drains one result per cycle while the master side is
// ready. A result passes the input register and the queue on its way out. An item
// is parsed only while the queue holds at most two results, so a stalled master
// side drops s_axis_tready once three results wait and the input register is full.
// Reset clears the parser to wait for a record's checksum bytes and empties
// the queue; after any failure result the block ignores input until reset.
module log_record_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,   // [0] end_of_log
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] byte_value, [15:8] record_kind, [47:16] key_length, [79:48] value_length
  output logic [79:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast
);
  import rld_pkg::*;

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_eol_q;
  logic        room;
  logic        step;
  rld_push_t   push;
  rld_result_t head;

  assign step          = in_valid_q && room;
  assign s_axis_tready = !in_valid_q || step;

  // Hold the accepted request until the parser takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_eol_q  <= s_axis_tuser[0];
    end
  end

  rld_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .data_byte_i  (in_byte_q),
    .end_of_log_i (in_eol_q),
    .push_o       (push)
  );

  rld_out_fifo u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (m_axis_tready),
    .head_o  (head),
    .valid_o (m_axis_tvalid),
    .room_o  (room)
  );

  // Pack the head result onto the master side
  assign m_axis_tdata = {head.value_length, head.key_length, head.record_kind,
                         head.byte_value};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last_of_run;

  // The input register is never overwritten while it still holds a request
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !room) |=> (in_valid_q && $stable(in_byte_q) && $stable(in_eol_q)))
    else $error("pending input request lost");

endmodule
